@@ rtl/rab_pkg.sv @@
// rab_pkg: shared types and constants of the rgba alpha blend pixel unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rab_pkg;

    // destination depth codes
    localparam logic [1:0] FMT_16 = 2'd0;
    localparam logic [1:0] FMT_24 = 2'd1;
    localparam logic [1:0] FMT_32 = 2'd2;

    // configuration register indexes
    localparam logic CFG_PIXEL_FORMAT = 1'b0;
    localparam logic CFG_GLOBAL_TRANSP = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] PIXEL_FORMAT_RST = FMT_32;
    localparam logic [7:0] GLOBAL_TRANSP_RST = 8'd255;

    // mode codes
    localparam logic MODE_NORMAL = 1'b0;
    localparam logic MODE_GHOST = 1'b1;

    // alpha special values
    localparam logic [7:0] ALPHA_ZERO = 8'd0;
    localparam logic [7:0] ALPHA_FULL = 8'd255;

    // divide by three for the grey sum (exact for sums up to 765)
    localparam logic [10:0] GREY_RECIP = 11'd683;

    // denominators and their truncated reciprocals scaled by 2^24
    localparam logic [15:0] DEN_NORMAL = 16'd255;
    localparam logic [15:0] DEN_GHOST = 16'd65025;
    localparam logic [16:0] RECIP_NORMAL = 17'd65793;
    localparam logic [16:0] RECIP_GHOST = 17'd258;

    localparam logic [31:0] ALPHA_BYTE_MASK = 32'hff000000;

    // sideband that travels alongside the lanes
    typedef struct packed {
        logic [1:0]      fmt;
        logic            skip;
        logic            copy;
        logic [31:0]     dest;
        logic [2:0][7:0] src;
    } ctrl_t;

endpackage

`default_nettype wire

@@ rtl/rab_front.sv @@
// rab_front: input decode stage, unpacks the destination channels, forms grey and scale
// depends on rab_pkg
`timescale 1ns / 1ps
`default_nettype none

module rab_front (
    input  wire logic                   aclk,
    input  wire logic                   load,
    input  wire logic [1:0]             pixel_format,
    input  wire logic [7:0]             global_transp,
    input  wire logic                   mode,
    input  wire logic [7:0]             src_c0,
    input  wire logic [7:0]             src_c1,
    input  wire logic [7:0]             src_c2,
    input  wire logic [7:0]             src_alpha,
    input  wire logic [31:0]            dest_pixel,
    output logic [2:0][7:0]             d_ch,
    output logic [2:0][7:0]             s_ch,
    output logic [15:0]                 num,
    output logic                        ghost,
    output rab_pkg::ctrl_t              ctrl
);
    import rab_pkg::*;

    logic [1:0]      fmt_eff;
    logic [9:0]      grey_sum;
    logic [20:0]     grey_prod;
    logic [7:0]      grey;
    logic [15:0]     scale;
    logic [2:0][7:0] d_next;
    logic [2:0][7:0] s_next;
    logic [15:0]     num_next;
    ctrl_t           ctrl_next;

    logic [2:0][7:0] d_ch_reg;
    logic [2:0][7:0] s_ch_reg;
    logic [15:0]     num_reg;
    logic            ghost_reg;
    ctrl_t           ctrl_reg;

    // undefined depth code behaves as 32 bit
    always_comb begin
        unique case (pixel_format)
            FMT_16:  fmt_eff = FMT_16;
            FMT_24:  fmt_eff = FMT_24;
            default: fmt_eff = FMT_32;
        endcase
    end

    // grey value by reciprocal multiply
    assign grey_sum  = {2'b00, src_c0} + {2'b00, src_c1} + {2'b00, src_c2};
    assign grey_prod = grey_sum * GREY_RECIP;
    assign grey      = grey_prod[18:11];

    // ghosted scale factor
    assign scale = src_alpha * global_transp;

    // destination channels per format
    always_comb begin
        if (fmt_eff == FMT_16) begin
            d_next[0] = {dest_pixel[4:0], 3'b000};
            d_next[1] = {dest_pixel[10:6], 3'b000};
            d_next[2] = {dest_pixel[15:11], 3'b000};
        end else begin
            d_next[0] = dest_pixel[7:0];
            d_next[1] = dest_pixel[15:8];
            d_next[2] = dest_pixel[23:16];
        end
    end

    // source and numerator per mode
    always_comb begin
        if (mode == MODE_GHOST) begin
            s_next   = {grey, grey, grey};
            num_next = scale;
        end else begin
            s_next   = {src_c2, src_c1, src_c0};
            num_next = {8'd0, src_alpha};
        end
    end

    always_comb begin
        ctrl_next.fmt  = fmt_eff;
        ctrl_next.skip = (src_alpha == ALPHA_ZERO);
        ctrl_next.copy = (mode == MODE_NORMAL) && (src_alpha == ALPHA_FULL);
        ctrl_next.dest = dest_pixel;
        ctrl_next.src  = {src_c2, src_c1, src_c0};
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (load) begin
            d_ch_reg  <= d_next;
            s_ch_reg  <= s_next;
            num_reg   <= num_next;
            ghost_reg <= mode;
            ctrl_reg  <= ctrl_next;
        end
    end

    assign d_ch  = d_ch_reg;
    assign s_ch  = s_ch_reg;
    assign num   = num_reg;
    assign ghost = ghost_reg;
    assign ctrl  = ctrl_reg;

endmodule

`default_nettype wire

@@ rtl/rab_lane.sv @@
// rab_lane: one colour channel, d + trunc((s - d) * num / den) over three stages
// depends on rab_pkg
`timescale 1ns / 1ps
`default_nettype none

module rab_lane (
    input  wire logic        aclk,
    input  wire logic        load_b,
    input  wire logic        load_c,
    input  wire logic        load_d,
    input  wire logic [7:0]  d_in,
    input  wire logic [7:0]  s_in,
    input  wire logic [15:0] num,
    input  wire logic        ghost,
    output logic [7:0]       ch_out
);
    import rab_pkg::*;

    logic [8:0]  diff;
    logic [7:0]  mag;
    logic [23:0] prod_next;
    logic [16:0] recip;
    logic [40:0] est_full;
    logic [15:0] den;
    logic [23:0] back;
    logic [23:0] rem;
    logic [7:0]  quot;
    logic [7:0]  ch_next;

    logic [23:0] prod_b_reg;
    logic        neg_b_reg;
    logic        ghost_b_reg;
    logic [7:0]  d_b_reg;
    logic [23:0] prod_c_reg;
    logic [7:0]  q_c_reg;
    logic        neg_c_reg;
    logic        ghost_c_reg;
    logic [7:0]  d_c_reg;
    logic [7:0]  ch_reg;

    // magnitude of the difference times numerator
    assign diff      = {1'b0, s_in} - {1'b0, d_in};
    assign mag       = diff[8] ? 8'(-diff) : diff[7:0];
    assign prod_next = mag * num;

    always_ff @(posedge aclk) begin
        if (load_b) begin
            prod_b_reg  <= prod_next;
            neg_b_reg   <= diff[8];
            ghost_b_reg <= ghost;
            d_b_reg     <= d_in;
        end
    end

    // quotient estimate, low by at most one
    assign recip    = ghost_b_reg ? RECIP_GHOST : RECIP_NORMAL;
    assign est_full = prod_b_reg * recip;

    always_ff @(posedge aclk) begin
        if (load_c) begin
            prod_c_reg  <= prod_b_reg;
            q_c_reg     <= est_full[31:24];
            neg_c_reg   <= neg_b_reg;
            ghost_c_reg <= ghost_b_reg;
            d_c_reg     <= d_b_reg;
        end
    end

    // remainder correction, then apply the signed step
    assign den     = ghost_c_reg ? DEN_GHOST : DEN_NORMAL;
    assign back    = q_c_reg * den;
    assign rem     = prod_c_reg - back;
    assign quot    = q_c_reg + {7'd0, (rem >= {8'd0, den})};
    assign ch_next = neg_c_reg ? (d_c_reg - quot) : (d_c_reg + quot);

    always_ff @(posedge aclk) begin
        if (load_d) begin
            ch_reg <= ch_next;
        end
    end

    assign ch_out = ch_reg;

endmodule

`default_nettype wire

@@ rtl/rab_merge.sv @@
// rab_merge: packs the lane results into the destination format and holds the output word
// depends on rab_pkg
`timescale 1ns / 1ps
`default_nettype none

module rab_merge (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire rab_pkg::ctrl_t  ctrl,
    input  wire logic [2:0][7:0] ch,
    input  wire logic            out_ready,
    output logic                 load,
    output logic                 out_valid,
    output logic [31:0]          out_pixel
);
    import rab_pkg::*;

    logic [2:0][7:0] pick;
    logic [31:0]     packed_px;
    logic [31:0]     keep_mask;
    logic [31:0]     pixel_next;
    logic [31:0]     pixel_reg;
    logic            valid_reg;

    // copy takes the source bytes, a blend takes the lanes
    assign pick = ctrl.copy ? ctrl.src : ch;

    always_comb begin
        unique case (ctrl.fmt)
            FMT_16: begin
                packed_px = {16'd0, pick[2][7:3], pick[1][7:3], 1'b0, pick[0][7:3]};
                keep_mask = 32'h0000ffff;
            end
            FMT_24: begin
                packed_px = {8'd0, pick[2], pick[1], pick[0]};
                keep_mask = 32'h00ffffff;
            end
            default: begin
                packed_px = {8'd0, pick[2], pick[1], pick[0]}
                          | (ctrl.copy ? ALPHA_BYTE_MASK : (ctrl.dest & ALPHA_BYTE_MASK));
                keep_mask = 32'hffffffff;
            end
        endcase
    end

    // skipped pixel passes the destination through
    assign pixel_next = ctrl.skip ? (ctrl.dest & keep_mask) : packed_px;

    assign load = !valid_reg || out_ready;

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

`default_nettype wire

@@ rtl/rgba_alpha_blend_pixel_unit.sv @@
// rgba_alpha_blend_pixel_unit: top level of the pixel blender
// depends on rab_pkg, rab_front, rab_lane, rab_merge
`timescale 1ns / 1ps
`default_nettype none

// Blends one source pixel into one destination pixel per word. The unit takes a
// new word every clock and delivers one result word per clock while m_ready is
// high; each word passes through a decode stage, three stages in each of the
// three channel lanes (multiply, reciprocal estimate, remainder correction) and
// the output register of the merge stage. Every stage stalls only when the one
// after it is full; a waiting result stops new words only once every stage is full.
// pixel_format and global_transparency are written through cfg_we / cfg_index /
// cfg_wdata and should change only while no word is in flight.

module rgba_alpha_blend_pixel_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [rab_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rab_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_mode,
    input  wire logic [7:0]                      s_src_c0,
    input  wire logic [7:0]                      s_src_c1,
    input  wire logic [7:0]                      s_src_c2,
    input  wire logic [7:0]                      s_src_alpha,
    input  wire logic [31:0]                     s_dest_pixel,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [31:0]                          m_result_pixel
);
    import rab_pkg::*;

    logic [1:0]      pixel_format_reg;
    logic [7:0]      global_transp_reg;

    logic            load_a;
    logic            load_b;
    logic            load_c;
    logic            load_d;
    logic            load_o;
    logic            valid_a_reg;
    logic            valid_b_reg;
    logic            valid_c_reg;
    logic            valid_d_reg;

    logic [2:0][7:0] d_ch;
    logic [2:0][7:0] s_ch;
    logic [15:0]     num;
    logic            ghost;
    ctrl_t           ctrl_a;
    ctrl_t           ctrl_b_reg;
    ctrl_t           ctrl_c_reg;
    ctrl_t           ctrl_d_reg;
    logic [2:0][7:0] ch;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg  <= PIXEL_FORMAT_RST;
            global_transp_reg <= GLOBAL_TRANSP_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PIXEL_FORMAT:  pixel_format_reg  <= cfg_wdata[1:0];
                CFG_GLOBAL_TRANSP: global_transp_reg <= cfg_wdata[7:0];
                default:           pixel_format_reg  <= pixel_format_reg;
            endcase
        end
    end

    // stage enables, each stage loads when empty or when it drains
    assign load_d  = !valid_d_reg || load_o;
    assign load_c  = !valid_c_reg || load_d;
    assign load_b  = !valid_b_reg || load_c;
    assign load_a  = !valid_a_reg || load_b;
    assign s_ready = load_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end else begin
            if (load_a) valid_a_reg <= s_valid;
            if (load_b) valid_b_reg <= valid_a_reg;
            if (load_c) valid_c_reg <= valid_b_reg;
            if (load_d) valid_d_reg <= valid_c_reg;
        end
    end

    // sideband pipeline alongside the lanes
    always_ff @(posedge aclk) begin
        if (load_b) ctrl_b_reg <= ctrl_a;
        if (load_c) ctrl_c_reg <= ctrl_b_reg;
        if (load_d) ctrl_d_reg <= ctrl_c_reg;
    end

    // decode stage
    rab_front u_front (
        .aclk          (aclk),
        .load          (load_a),
        .pixel_format  (pixel_format_reg),
        .global_transp (global_transp_reg),
        .mode          (s_mode),
        .src_c0        (s_src_c0),
        .src_c1        (s_src_c1),
        .src_c2        (s_src_c2),
        .src_alpha     (s_src_alpha),
        .dest_pixel    (s_dest_pixel),
        .d_ch          (d_ch),
        .s_ch          (s_ch),
        .num           (num),
        .ghost         (ghost),
        .ctrl          (ctrl_a)
    );

    // one lane per colour channel
    for (genvar i = 0; i < 3; i++) begin : g_lane
        rab_lane u_lane (
            .aclk   (aclk),
            .load_b (load_b),
            .load_c (load_c),
            .load_d (load_d),
            .d_in   (d_ch[i]),
            .s_in   (s_ch[i]),
            .num    (num),
            .ghost  (ghost),
            .ch_out (ch[i])
        );
    end

    // pack and hold the output word
    rab_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_d_reg),
        .ctrl      (ctrl_d_reg),
        .ch        (ch),
        .out_ready (m_ready),
        .load      (load_o),
        .out_valid (m_valid),
        .out_pixel (m_result_pixel)
    );

endmodule

`default_nettype wire

@@ rtl/rab_checker.sv @@
// rab_checker: port-level checks of the pixel blender, bound to the top level
// depends on rab_pkg and rgba_alpha_blend_pixel_unit
`timescale 1ns / 1ps
`default_nettype none

module rab_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [rab_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rab_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire logic [31:0]                     m_result_pixel
);
    import rab_pkg::*;

    logic [3:0] inflight_reg;
    logic [1:0] fmt_reg;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    // words accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= 4'd0;
        end else begin
            inflight_reg <= inflight_reg + {3'd0, s_acc} - {3'd0, m_acc};
        end
    end

    // shadow of the depth register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= PIXEL_FORMAT_RST;
        end else if (cfg_we && cfg_index == CFG_PIXEL_FORMAT) begin
            fmt_reg <= cfg_wdata[1:0];
        end
    end

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_pixel))
        else $error("result word changed while stalled");

    // no result without a word inside
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 4'd0)
        else $error("result word without an accepted input word");

    // pipeline never holds more than its stages
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 4'd5)
        else $error("more words in flight than stages");

    // unused high bits stay clear in the narrow formats
    a_high_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !cfg_we && !$past(cfg_we) && inflight_reg != 4'd0
        |-> (fmt_reg != FMT_16 || m_result_pixel[31:16] == 16'd0)
         && (fmt_reg != FMT_24 || m_result_pixel[31:24] == 8'd0))
        else $error("high bits set in a narrow pixel format");

endmodule

bind rgba_alpha_blend_pixel_unit rab_checker u_rab_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_pixel (m_result_pixel)
);

`default_nettype wire
